// ===== hw/rtl/ksat_pkg.sv =====
// Shared types and constants of the keyed score average table.
package ksat_pkg;

    localparam int TableEntriesDefault = 64;
    localparam logic [15:0] TallyMax = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } command_t;

    typedef struct packed {
        logic               command;
        logic signed [31:0] key_id;
        logic signed [15:0] score;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [23:0] average;
        logic [15:0]        entry_count;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DECIDE,
        S_DIV_START,
        S_DIV,
        S_DIV_DONE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_step;
        logic do_write;
        logic write_new;
        logic div_start;
        logic div_step;
        logic div_finish;
        logic set_result;
        logic [1:0] result_status;
    } ctrl_t;

    typedef struct packed {
        logic is_query;
        logic scan_last;
        logic hit;
        logic free_found;
        logic tally_full;
        logic div_last;
    } stat_t;

endpackage

// ===== hw/rtl/keyed_score_average_table_top.sv =====
// Top level of the keyed score average table.
// An insert or query first scans the entries; a query that finds its key then runs the divider.
// The scan reads entries one at a time from the store and stops at the first key match.
// Throughput: one word at a time; the next word is taken once the result has been taken.
// Reset clears all valid bits at once, so the table is empty and usable right after reset.
module keyed_score_average_table_top #(
    parameter int TABLE_ENTRIES = ksat_pkg::TableEntriesDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ksat_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ksat_pkg::out_word_t m_data
);
    import ksat_pkg::*;

    ctrl_t ctl;
    stat_t st;

    ksat_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .st(st), .ctl(ctl)
    );

    ksat_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_word(s_data), .ctl(ctl), .st(st),
        .m_word(m_data)
    );

endmodule

// ===== hw/rtl/ksat_ctrl.sv =====
// Controller state machine of the keyed score average table.
module ksat_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  ksat_pkg::stat_t st,
    output ksat_pkg::ctrl_t ctl
);
    import ksat_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load = 1'b1;
                    ctl.scan_clear = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (st.hit || st.scan_last) begin
                    state_next = S_DECIDE;
                end else begin
                    ctl.scan_step = 1'b1;
                    state_next = S_READ;
                end
            end
            S_DECIDE: begin
                ctl.set_result = 1'b1;
                if (st.is_query) begin
                    if (st.hit) begin
                        state_next = S_DIV_START;
                    end else begin
                        ctl.result_status = ST_NOT_FOUND;
                        state_next = S_OUT;
                    end
                end else if (st.hit) begin
                    if (st.tally_full) begin
                        ctl.result_status = ST_SATURATED;
                    end else begin
                        ctl.do_write = 1'b1;
                    end
                    state_next = S_OUT;
                end else if (st.free_found) begin
                    ctl.do_write = 1'b1;
                    ctl.write_new = 1'b1;
                    state_next = S_OUT;
                end else begin
                    ctl.result_status = ST_TABLE_FULL;
                    state_next = S_OUT;
                end
            end
            S_DIV_START: begin
                ctl.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                ctl.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = S_DIV_DONE;
                end
            end
            S_DIV_DONE: begin
                ctl.div_finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ksat_datapath.sv =====
// Datapath of the keyed score average table: entry store, scan and divider.
module ksat_datapath #(
    parameter int TABLE_ENTRIES = ksat_pkg::TableEntriesDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ksat_pkg::in_word_t  s_word,
    input  ksat_pkg::ctrl_t     ctl,
    output ksat_pkg::stat_t     st,
    output ksat_pkg::out_word_t m_word
);
    import ksat_pkg::*;

    localparam int IdxW = $clog2(TABLE_ENTRIES);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [31:0] key_mem [TABLE_ENTRIES];
    logic [31:0] sum_mem [TABLE_ENTRIES];
    logic [15:0] tally_mem [TABLE_ENTRIES];

    in_word_t   item_reg;
    logic [IdxW-1:0] idx_reg;
    logic [IdxW-1:0] free_idx_reg;
    logic       free_found_reg;
    logic       hit_reg;
    logic [31:0] rd_key_reg, rd_sum_reg;
    logic [15:0] rd_tally_reg;
    logic       rd_valid_reg;
    out_word_t  out_reg;

    logic [39:0] rem_reg;
    logic [39:0] quo_reg;
    logic        neg_reg;
    logic [5:0]  dcnt_reg;

    logic match;
    assign match = rd_valid_reg && (rd_key_reg == item_reg.key_id);

    assign st.is_query   = (item_reg.command == CMD_QUERY);
    assign st.scan_last  = (idx_reg == IdxW'(TABLE_ENTRIES - 1));
    assign st.hit        = hit_reg || match;
    assign st.free_found = free_found_reg;
    assign st.tally_full = (rd_tally_reg == TallyMax);
    assign st.div_last   = (dcnt_reg == 6'd39);
    assign m_word = out_reg;

    always_ff @(posedge aclk) begin
        rd_key_reg   <= key_mem[idx_reg];
        rd_sum_reg   <= sum_mem[idx_reg];
        rd_tally_reg <= tally_mem[idx_reg];
        rd_valid_reg <= valid_reg[idx_reg];
    end

    logic [IdxW-1:0] wr_idx;
    logic [31:0] score_ext;
    assign wr_idx = ctl.write_new ? free_idx_reg : idx_reg;
    assign score_ext = {{16{item_reg.score[15]}}, item_reg.score};

    always_ff @(posedge aclk) begin
        if (ctl.do_write) begin
            if (ctl.write_new) begin
                key_mem[wr_idx]   <= item_reg.key_id;
                sum_mem[wr_idx]   <= score_ext;
                tally_mem[wr_idx] <= 16'd1;
            end else begin
                sum_mem[wr_idx]   <= rd_sum_reg + score_ext;
                tally_mem[wr_idx] <= rd_tally_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.do_write && ctl.write_new) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            item_reg <= s_word;
        end
        if (ctl.scan_clear) begin
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (ctl.set_result) begin
            hit_reg <= hit_reg || match;
        end else if (ctl.scan_step) begin
            idx_reg <= idx_reg + 1'b1;
            if (!rd_valid_reg && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
        end else if (st.scan_last && !rd_valid_reg && !free_found_reg && !match) begin
            free_found_reg <= 1'b1;
            free_idx_reg   <= idx_reg;
        end
    end

    // Restoring division of |sum| * 256 by the tally, one quotient bit a cycle.
    logic [40:0] shifted;
    logic [40:0] diff;
    always_comb begin
        shifted = {1'b0, rem_reg[38:0], quo_reg[39]};
        diff = shifted - {25'd0, rd_tally_reg};
    end

    always_ff @(posedge aclk) begin
        if (ctl.div_start) begin
            neg_reg  <= rd_sum_reg[31];
            rem_reg  <= '0;
            quo_reg  <= {(rd_sum_reg[31] ? (32'd0 - rd_sum_reg) : rd_sum_reg), 8'd0};
            dcnt_reg <= '0;
        end else if (ctl.div_step) begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (!diff[40]) begin
                rem_reg <= diff[39:0];
                quo_reg <= {quo_reg[38:0], 1'b1};
            end else begin
                rem_reg <= shifted[39:0];
                quo_reg <= {quo_reg[38:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.set_result) begin
            out_reg.status  <= ctl.result_status;
            out_reg.average <= '0;
            if (ctl.result_status == ST_SATURATED) begin
                out_reg.entry_count <= TallyMax;
            end else if (ctl.result_status != ST_OK) begin
                out_reg.entry_count <= '0;
            end else if (item_reg.command == CMD_QUERY) begin
                out_reg.entry_count <= rd_tally_reg;
            end else if (ctl.write_new) begin
                out_reg.entry_count <= 16'd1;
            end else begin
                out_reg.entry_count <= rd_tally_reg + 16'd1;
            end
        end else if (ctl.div_finish) begin
            out_reg.average <= neg_reg ? (24'd0 - quo_reg[23:0]) : quo_reg[23:0];
        end
    end

endmodule

// ===== hw/rtl/ksat_checker.sv =====
// Port checker of the keyed score average table, bound to the top level.
module ksat_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ksat_pkg::out_word_t m_data
);
    import ksat_pkg::*;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("word taken while result pending");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped or changed");

    a_avg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |-> (m_data.average == '0))
        else $error("nonzero average on failure");

    a_notfound_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == ST_NOT_FOUND || m_data.status == ST_TABLE_FULL))
        |-> (m_data.entry_count == '0)) else $error("count on missing key");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result after reset");

endmodule

bind keyed_score_average_table_top ksat_checker u_ksat_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// ===== tb/keyed_score_average_table_top_test.sv =====
// Randomized self-checking testbench for the keyed score average table top level.
`timescale 1ns / 100ps

module keyed_score_average_table_top_test;
    import ksat_pkg::*;

    localparam int Entries = TableEntriesDefault;
    localparam int CycleLimit = 10000000;

    class average_table_board;
        bit          held[Entries];
        logic [31:0] keys[Entries];
        logic [31:0] sums[Entries];
        logic [15:0] tallies[Entries];
        out_word_t   pending[$];
        int          errors;

        function void clear();
            foreach (held[i]) held[i] = 1'b0;
            pending.delete();
            errors = 0;
        endfunction

        function logic [23:0] scaled_mean(logic [31:0] sum, logic [15:0] tally);
            logic [63:0] mag;
            logic [63:0] q;
            mag = sum[31] ? {32'd0, -sum} : {32'd0, sum};
            if (tally == 16'd0) return 24'd0;
            q = (mag << 8) / {48'd0, tally};
            if (sum[31]) q = -q;
            return q[23:0];
        endfunction

        function void note_word(in_word_t w);
            out_word_t r;
            int slot;
            int spare;
            logic [31:0] ext;
            slot = -1;
            spare = -1;
            r = '0;
            ext = {{16{w.score[15]}}, w.score};
            for (int i = Entries - 1; i >= 0; i--) begin
                if (held[i] && keys[i] == w.key_id) slot = i;
                if (!held[i]) spare = i;
            end
            if (w.command == CMD_INSERT) begin
                if (slot >= 0) begin
                    if (tallies[slot] == TallyMax) begin
                        r.status = ST_SATURATED;
                        r.entry_count = TallyMax;
                    end else begin
                        sums[slot] = sums[slot] + ext;
                        tallies[slot] = tallies[slot] + 16'd1;
                        r.status = ST_OK;
                        r.entry_count = tallies[slot];
                    end
                end else if (spare < 0) begin
                    r.status = ST_TABLE_FULL;
                end else begin
                    held[spare] = 1'b1;
                    keys[spare] = w.key_id;
                    sums[spare] = ext;
                    tallies[spare] = 16'd1;
                    r.status = ST_OK;
                    r.entry_count = 16'd1;
                end
            end else if (slot < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                r.status = ST_OK;
                r.entry_count = tallies[slot];
                r.average = scaled_mean(sums[slot], tallies[slot]);
            end
            pending = {pending, r};
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.average !== want.average) begin
                $error("average: expected %0d, got %0d", want.average, got.average);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d",
                       want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    average_table_board board;
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;
    logic [31:0] key_pool[16];

    keyed_score_average_table_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        board = new();
        board.clear();
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("keyed_score_average_table_top: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_word(m_data);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(logic cmd, logic [31:0] key, logic [15:0] score);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= '{command: cmd, key_id: key, score: score};
        do @(posedge aclk); while (!s_ready);
        board.note_word(s_data);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic random_word(int pool_size);
        logic [31:0] key;
        logic [15:0] score;
        logic cmd;
        key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(pool_size - 1)];
        score = 16'($urandom);
        if ($urandom_range(3) == 0) score = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        cmd = ($urandom_range(2) == 0);
        send_word(cmd, key, score);
    endtask

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(CMD_QUERY, 32'h8000_0000, 16'h0);
        send_word(CMD_INSERT, 32'h8000_0000, 16'h8000);
        send_word(CMD_INSERT, 32'h8000_0000, 16'h8000);
        send_word(CMD_QUERY, 32'h8000_0000, 16'h1234);
        send_word(CMD_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
        send_word(CMD_INSERT, 32'h7FFF_FFFF, 16'h0);
        send_word(CMD_INSERT, 32'h7FFF_FFFF, 16'h0);
        send_word(CMD_QUERY, 32'h7FFF_FFFF, 16'hFFFF);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 16'h0);
        send_word(CMD_QUERY, 32'hFFFF_FFFF, 16'h0);
        send_word(CMD_INSERT, 32'h0, 16'h0);
        send_word(CMD_QUERY, 32'h0, 16'h0);
        send_word(CMD_QUERY, 32'h5555_AAAA, 16'h0);
        drain();

        // Fill the table, then one new key must be turned away.
        for (int i = 0; i < Entries; i++) begin
            if (i >= 4) send_word(CMD_INSERT, 32'h1000 + i, 16'($urandom));
        end
        send_word(CMD_INSERT, 32'hDEAD_0001, 16'h1);
        send_word(CMD_QUERY, 32'hDEAD_0001, 16'h1);

        // Saturate one key's tally.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int n = 0; n < 65534; n++) send_word(CMD_INSERT, 32'h1004, 16'h8000);
        send_word(CMD_INSERT, 32'h1004, 16'h7FFF);
        send_word(CMD_QUERY, 32'h1004, 16'h0);
        drain();

        for (int p = 0; p < 16; p++) key_pool[p] = 32'h1000 + p + 4;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 75; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 75; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int n = 0; n < 475; n++) begin
                random_word(16);
                if (n == 200) drain();
            end
        end
        drain();
        repeat (200) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("keyed_score_average_table_top: match");
        end else begin
            $display("keyed_score_average_table_top: mismatch");
        end
        $finish;
    end
endmodule
